// File: rtl/mdls_pkg.sv
package mdls_pkg;

  localparam int DEPTH_BITS_DEFAULT    = 16;
  localparam int FRACTION_BITS_DEFAULT = 16;

  localparam int DEPTH_FIELD_W = 16;
  localparam int FRAC_REG_W    = 17;
  localparam int NUM_LAYERS    = 3;
  localparam int CFG_INDEX_W   = 2;
  localparam int IN_TDATA_W    = 24;
  localparam int OUT_TDATA_W   = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_LAYER_ONE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LAYER_TWO   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LAYER_THREE = 2'd2;

  localparam logic [FRAC_REG_W-1:0] LAYER_ONE_RESET   = 17'd16384;
  localparam logic [FRAC_REG_W-1:0] LAYER_TWO_RESET   = 17'd32768;
  localparam logic [FRAC_REG_W-1:0] LAYER_THREE_RESET = 17'd49152;

  localparam logic REQ_MEASURE  = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  typedef struct packed {
    logic                     classify;
    logic                     masked;
    logic                     start;
    logic                     last;
    logic [DEPTH_FIELD_W-1:0] depth;
  } item_t;

endpackage

// File: rtl/mdls_track.sv
module mdls_track
  import mdls_pkg::*;
#(
  parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  item_t                 in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output item_t                 out_item,
  output logic [DEPTH_BITS-1:0] out_near,
  output logic                  out_neg,
  output logic [DEPTH_BITS-1:0] out_mag
);

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

  logic                  v1;
  item_t                 item1;
  logic                  v2;
  item_t                 item2;
  logic [DEPTH_BITS-1:0] near2;
  logic                  neg2;
  logic [DEPTH_BITS-1:0] mag2;

  logic [DEPTH_BITS-1:0] nearest;
  logic [DEPTH_BITS-1:0] farthest;
  logic [DEPTH_BITS-1:0] nearest_next;
  logic [DEPTH_BITS-1:0] farthest_next;
  logic [DEPTH_BITS-1:0] depth1;
  logic [DEPTH_BITS:0]   diff;
  logic [DEPTH_BITS:0]   diff_neg;
  logic                  ready1;
  logic                  fire1;

  assign ready1   = !v2 || out_ready;
  assign fire1    = v1 && ready1;
  assign in_ready = !v1 || ready1;
  assign depth1   = item1.depth[DEPTH_BITS-1:0];

  always_comb begin
    nearest_next  = nearest;
    farthest_next = farthest;
    if (fire1 && item1.classify == REQ_MEASURE) begin
      if (item1.start) begin
        nearest_next  = DEPTH_MAX;
        farthest_next = '0;
      end
      if (item1.masked) begin
        if (depth1 > farthest_next) begin
          farthest_next = depth1;
        end
        if (depth1 != '0 && depth1 < nearest_next) begin
          nearest_next = depth1;
        end
      end
    end
  end

  // Range of the frame seen so far, including the item now leaving stage one.
  assign diff     = {1'b0, farthest_next} - {1'b0, nearest_next};
  assign diff_neg = -diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      nearest  <= DEPTH_MAX;
      farthest <= '0;
    end else begin
      nearest  <= nearest_next;
      farthest <= farthest_next;
      if (in_ready) begin
        v1 <= in_valid;
      end
      if (ready1) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item1 <= in_item;
    end
    if (fire1) begin
      item2 <= item1;
      near2 <= nearest_next;
      neg2  <= diff[DEPTH_BITS];
      mag2  <= diff[DEPTH_BITS] ? diff_neg[DEPTH_BITS-1:0] : diff[DEPTH_BITS-1:0];
    end
  end

  assign out_valid = v2;
  assign out_item  = item2;
  assign out_near  = near2;
  assign out_neg   = neg2;
  assign out_mag   = mag2;

endmodule

// File: rtl/mdls_scale.sv
module mdls_scale
  import mdls_pkg::*;
#(
  parameter int DEPTH_BITS    = DEPTH_BITS_DEFAULT,
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [CFG_INDEX_W-1:0]                cfg_index,
  input  logic [FRAC_REG_W-1:0]                 cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  item_t                                 in_item,
  input  logic [DEPTH_BITS-1:0]                 in_near,
  input  logic                                  in_neg,
  input  logic [DEPTH_BITS-1:0]                 in_mag,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output item_t                                 out_item,
  output logic [DEPTH_BITS-1:0]                 out_near,
  output logic                                  out_neg,
  output logic [NUM_LAYERS-1:0][DEPTH_BITS-1:0] out_scaled
);

  localparam int FRAC_W = FRACTION_BITS + 1;
  localparam int EXT_W  = (FRAC_REG_W > FRAC_W) ? FRAC_REG_W : FRAC_W;
  localparam int PROD_W = DEPTH_BITS + FRAC_W;
  localparam logic [EXT_W-1:0] FRAC_ONE = EXT_W'(1) << FRACTION_BITS;

  logic [NUM_LAYERS-1:0][FRAC_REG_W-1:0] fraction;
  logic [NUM_LAYERS-1:0][FRAC_W-1:0]     frac_sat;
  logic [NUM_LAYERS-1:0][EXT_W-1:0]      frac_ext;
  logic [NUM_LAYERS-1:0][PROD_W-1:0]     product;

  logic                                  v3;
  item_t                                 item3;
  logic [DEPTH_BITS-1:0]                 near3;
  logic                                  neg3;
  logic [NUM_LAYERS-1:0][DEPTH_BITS-1:0] scaled3;

  assign in_ready = !v3 || out_ready;

  // Fractions above one are held at exactly one, so the product never
  // exceeds the range magnitude.
  always_comb begin
    for (int k = 0; k < NUM_LAYERS; k++) begin
      frac_ext[k] = EXT_W'(fraction[k]);
      if (frac_ext[k] > FRAC_ONE) begin
        frac_ext[k] = FRAC_ONE;
      end
      frac_sat[k] = frac_ext[k][FRAC_W-1:0];
      product[k]  = PROD_W'(in_mag) * PROD_W'(frac_sat[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fraction[0] <= LAYER_ONE_RESET;
      fraction[1] <= LAYER_TWO_RESET;
      fraction[2] <= LAYER_THREE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LAYER_ONE: begin
          fraction[0] <= cfg_data;
        end
        REG_LAYER_TWO: begin
          fraction[1] <= cfg_data;
        end
        REG_LAYER_THREE: begin
          fraction[2] <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (in_ready) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item3 <= in_item;
      near3 <= in_near;
      neg3  <= in_neg;
      for (int k = 0; k < NUM_LAYERS; k++) begin
        scaled3[k] <= product[k][FRACTION_BITS +: DEPTH_BITS];
      end
    end
  end

  assign out_valid  = v3;
  assign out_item   = item3;
  assign out_near   = near3;
  assign out_neg    = neg3;
  assign out_scaled = scaled3;

endmodule

// File: rtl/mdls_classify.sv
module mdls_classify
  import mdls_pkg::*;
#(
  parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  item_t                                 in_item,
  input  logic [DEPTH_BITS-1:0]                 in_near,
  input  logic                                  in_neg,
  input  logic [NUM_LAYERS-1:0][DEPTH_BITS-1:0] in_scaled,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [NUM_LAYERS-1:0]                 out_bits,
  output logic                                  out_last
);

  localparam int CUT_W = DEPTH_BITS + 2;

  logic signed [CUT_W-1:0] cuts [NUM_LAYERS];
  logic signed [CUT_W-1:0] cut_new [NUM_LAYERS];
  logic signed [CUT_W-1:0] depth_s;
  logic [NUM_LAYERS-1:0]   bits;
  logic                    fire;
  logic                    ov;
  logic [NUM_LAYERS-1:0]   obits;
  logic                    olast;

  // A measure item never waits for the output register.
  assign in_ready = (in_item.classify == REQ_MEASURE) || !ov || out_ready;
  assign fire     = in_valid && in_ready;
  assign depth_s  = CUT_W'(in_item.depth[DEPTH_BITS-1:0]);

  always_comb begin
    for (int k = 0; k < NUM_LAYERS; k++) begin
      if (in_neg) begin
        cut_new[k] = CUT_W'(in_near) - CUT_W'(in_scaled[k]);
      end else begin
        cut_new[k] = CUT_W'(in_near) + CUT_W'(in_scaled[k]);
      end
      bits[k] = in_item.masked && (depth_s <= cuts[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      for (int k = 0; k < NUM_LAYERS; k++) begin
        cuts[k] <= '0;
      end
    end else begin
      if (fire && in_item.classify == REQ_MEASURE && in_item.last) begin
        for (int k = 0; k < NUM_LAYERS; k++) begin
          cuts[k] <= cut_new[k];
        end
      end
      if (fire && in_item.classify == REQ_CLASSIFY) begin
        ov <= 1'b1;
      end else if (out_ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_item.classify == REQ_CLASSIFY) begin
      obits <= bits;
      olast <= in_item.last;
    end
  end

  assign out_valid = ov;
  assign out_bits  = obits;
  assign out_last  = olast;

endmodule

// File: rtl/masked_depth_layer_split_top.sv
// Splits a masked depth frame into three nested depth layers. The frame is
// streamed twice: measure items (tuser 0) track the nearest nonzero and the
// farthest masked depth, and the last measure item sets three cut depths at
// nearest plus the programmed fraction of the depth range; classify items
// (tuser 1) each return one item holding the three layer bits and a copy of
// tlast, while measure items return nothing. One item is taken every clock
// unless a held result back-pressures the pipeline; an accepted item moves
// from the input register through the tracking stage, the multiplier stage
// and the output register.
// A classify item may follow the last measure item in the very next cycle.
module masked_depth_layer_split_top
  import mdls_pkg::*;
#(
  parameter int DEPTH_BITS    = DEPTH_BITS_DEFAULT,
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [FRAC_REG_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // depth_sample [15:0], in_hand_mask [16], frame_start [17], zero pad [23:18]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // req_type [0]
  input  logic                   s_tuser,
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // layer_one_bit [0], layer_two_bit [1], layer_three_bit [2], zero pad [7:3]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast
);

  item_t                                 in_item;
  logic                                  t_valid;
  logic                                  t_ready;
  item_t                                 t_item;
  logic [DEPTH_BITS-1:0]                 t_near;
  logic                                  t_neg;
  logic [DEPTH_BITS-1:0]                 t_mag;
  logic                                  s3_valid;
  logic                                  s3_ready;
  item_t                                 s3_item;
  logic [DEPTH_BITS-1:0]                 s3_near;
  logic                                  s3_neg;
  logic [NUM_LAYERS-1:0][DEPTH_BITS-1:0] s3_scaled;
  logic [NUM_LAYERS-1:0]                 layer_bits;

  assign in_item.classify = s_tuser;
  assign in_item.depth    = s_tdata[DEPTH_FIELD_W-1:0];
  assign in_item.masked   = s_tdata[DEPTH_FIELD_W];
  assign in_item.start    = s_tdata[DEPTH_FIELD_W+1];
  assign in_item.last     = s_tlast;

  mdls_track #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_track (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .out_valid(t_valid),
    .out_ready(t_ready),
    .out_item (t_item),
    .out_near (t_near),
    .out_neg  (t_neg),
    .out_mag  (t_mag)
  );

  mdls_scale #(
    .DEPTH_BITS   (DEPTH_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (t_valid),
    .in_ready  (t_ready),
    .in_item   (t_item),
    .in_near   (t_near),
    .in_neg    (t_neg),
    .in_mag    (t_mag),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_item  (s3_item),
    .out_near  (s3_near),
    .out_neg   (s3_neg),
    .out_scaled(s3_scaled)
  );

  mdls_classify #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_classify (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s3_valid),
    .in_ready (s3_ready),
    .in_item  (s3_item),
    .in_near  (s3_near),
    .in_neg   (s3_neg),
    .in_scaled(s3_scaled),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_bits (layer_bits),
    .out_last (m_tlast)
  );

  assign m_tdata = OUT_TDATA_W'(layer_bits);

endmodule

// File: rtl/mdls_checker.sv
module mdls_checker
  import mdls_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tlast
);

  // Reset empties every stage, so nothing is offered and input is open.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_TDATA_W-1:NUM_LAYERS] == '0)
    else $error("output padding bits not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result item changed");

  // With the output empty, a new input always finds room in stage one.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !s_tready |=> s_tready)
    else $error("input held off with nothing to deliver");

endmodule

bind masked_depth_layer_split_top mdls_checker u_mdls_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);

// File: sim/masked_depth_layer_split_top_test.sv
`timescale 1ns / 100ps

module masked_depth_layer_split_top_test;
  import mdls_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 460;
  localparam int HOLD_CYCLES = 300;
  localparam longint FRAC_ONE = longint'(1) << FRACTION_BITS_DEFAULT;

  typedef struct packed {
    logic       last;
    logic [2:0] layers;
  } layer_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [FRAC_REG_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  item_t         pending_items[$];
  item_t         offered_item;
  layer_result_t layer_q[$];
  int            queued_items = 0;
  int            mismatches = 0;
  int            send_idle_pct = 20;
  int            recv_idle_pct = 79;
  bit            hold_armed = 1'b0;
  bit            hold_done = 1'b0;
  int            hold_left = 0;
  int            quiet_cycles = 0;

  // Predictor state for the tracked depths, the cut depths and the fractions.
  logic [15:0]           nearest_seen = 16'hFFFF;
  logic [15:0]           farthest_seen = 16'h0000;
  int                    layer_cut[NUM_LAYERS] = '{0, 0, 0};
  logic [FRAC_REG_W-1:0] layer_frac[NUM_LAYERS] =
    '{LAYER_ONE_RESET, LAYER_TWO_RESET, LAYER_THREE_RESET};

  string field_name[4] = '{"layer_one_bit", "layer_two_bit", "layer_three_bit", "last_out"};

  masked_depth_layer_split_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int form_cut(logic [FRAC_REG_W-1:0] frac_reg);
    longint span;
    longint frac;
    longint mag;
    frac = (longint'(frac_reg) > FRAC_ONE) ? FRAC_ONE : longint'(frac_reg);
    span = longint'(farthest_seen) - longint'(nearest_seen);
    // The product is truncated toward zero, so a negative range is scaled
    // by its magnitude.
    if (span < 0) begin
      mag = -(((-span) * frac) >> FRACTION_BITS_DEFAULT);
    end else begin
      mag = (span * frac) >> FRACTION_BITS_DEFAULT;
    end
    return int'(longint'(nearest_seen) + mag);
  endfunction

  task automatic predict_layers(item_t it);
    layer_result_t r;
    if (it.classify == REQ_CLASSIFY) begin
      for (int k = 0; k < NUM_LAYERS; k++) begin
        r.layers[k] = it.masked && (int'(it.depth) <= layer_cut[k]);
      end
      r.last = it.last;
      layer_q = {layer_q, r};
    end else begin
      if (it.start) begin
        nearest_seen = 16'hFFFF;
        farthest_seen = 16'h0000;
      end
      if (it.masked) begin
        if (it.depth > farthest_seen) farthest_seen = it.depth;
        if (it.depth != 16'd0 && it.depth < nearest_seen) nearest_seen = it.depth;
      end
      if (it.last) begin
        for (int k = 0; k < NUM_LAYERS; k++) layer_cut[k] = form_cut(layer_frac[k]);
      end
    end
  endtask

  // Driver: offers the next pending item once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_layers(offered_item);
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {6'b0, offered_item.start, offered_item.masked, offered_item.depth};
          s_tuser <= offered_item.classify;
          s_tlast <= offered_item.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result item and paces m_tready.
  always @(posedge clk) begin
    layer_result_t want;
    layer_result_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tlast, m_tdata[2:0]};
        if (layer_q.size() == 0) begin
          $display("%0t: result item with no expectation, expected none actual %b",
                   $time, got);
          mismatches++;
        end else begin
          want = layer_q.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (want[k] !== got[k]) begin
              $display("%0t: %s expected %b actual %b", $time, field_name[k], want[k], got[k]);
              mismatches++;
            end
          end
        end
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
        // Long hold-off so the pipeline fills and back-pressures the input.
        m_tready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(logic classify, logic [15:0] depth, logic masked, logic start,
                           logic last);
    item_t it;
    it.classify = classify;
    it.depth = depth;
    it.masked = masked;
    it.start = start;
    it.last = last;
    pending_items = {pending_items, it};
    queued_items++;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || s_tvalid || layer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_fraction(logic [CFG_INDEX_W-1:0] idx, logic [FRAC_REG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    layer_frac[idx] = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_depth(logic [15:0] base);
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1;
      3: return 16'($urandom);
      default: return base + 16'($urandom_range(0, 2000));
    endcase
  endfunction

  // One frame streamed twice: a measure pass, then a classify pass over the
  // same pixels. A few frames are broken on purpose.
  task automatic add_frame();
    int          n;
    bit          broken;
    logic [15:0] base;
    logic [15:0] depths[$];
    bit          masks[$];
    logic        start;
    logic        last;
    n = ($urandom_range(19) == 0) ? $urandom_range(30, 48) : $urandom_range(1, 12);
    broken = ($urandom_range(9) == 0);
    base = 16'($urandom);
    for (int k = 0; k < n; k++) begin
      depths = {depths, pick_depth(base)};
      masks = {masks, bit'($urandom_range(4) != 0)};
    end
    for (int k = 0; k < n; k++) begin
      start = (k == 0) ? !(broken && $urandom_range(1)) : (broken && $urandom_range(5) == 0);
      last = (k == n - 1) ? !(broken && $urandom_range(1)) : (broken && $urandom_range(5) == 0);
      push_item(REQ_MEASURE, depths[k], masks[k], start, last);
    end
    for (int k = 0; k < n; k++) begin
      push_item(REQ_CLASSIFY, depths[k], masks[k] ^ (broken && $urandom_range(3) == 0),
                1'($urandom_range(1)), k == n - 1);
    end
  endtask

  task automatic fill_random(int target);
    int goal;
    goal = queued_items + target;
    while (queued_items < goal) begin
      if ($urandom_range(6) == 0) begin
        push_item(1'($urandom_range(1)), 16'($urandom), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        add_frame();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Classify before any measure pass: every cut is still zero.
    push_item(REQ_CLASSIFY, 16'd0, 1'b1, 1'b0, 1'b0);
    push_item(REQ_CLASSIFY, 16'd1, 1'b1, 1'b0, 1'b0);
    push_item(REQ_CLASSIFY, 16'd0, 1'b0, 1'b0, 1'b1);
    // Ordinary frame; zero depths and unmasked pixels do not move the range.
    push_item(REQ_MEASURE, 16'd1000, 1'b1, 1'b1, 1'b0);
    push_item(REQ_MEASURE, 16'd5000, 1'b1, 1'b0, 1'b0);
    push_item(REQ_MEASURE, 16'd0, 1'b1, 1'b0, 1'b0);
    push_item(REQ_MEASURE, 16'd60000, 1'b0, 1'b0, 1'b0);
    push_item(REQ_MEASURE, 16'd3000, 1'b1, 1'b0, 1'b1);
    for (int k = 0; k < 6; k++) begin
      push_item(REQ_CLASSIFY, 16'(k * 1000), 1'b1, 1'b0, 1'b0);
    end
    push_item(REQ_CLASSIFY, 16'd1000, 1'b0, 1'b0, 1'b1);
    // Empty mask on a one-pixel frame gives a negative range.
    push_item(REQ_MEASURE, 16'd20000, 1'b0, 1'b1, 1'b1);
    push_item(REQ_CLASSIFY, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    push_item(REQ_CLASSIFY, 16'd40000, 1'b1, 1'b0, 1'b1);
    // A frame start on a classify item is ignored.
    push_item(REQ_MEASURE, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    push_item(REQ_CLASSIFY, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    push_item(REQ_CLASSIFY, 16'hFFFE, 1'b1, 1'b1, 1'b1);
    // Only zero depths in the mask.
    push_item(REQ_MEASURE, 16'd0, 1'b1, 1'b1, 1'b1);
    push_item(REQ_CLASSIFY, 16'd0, 1'b1, 1'b0, 1'b0);
    push_item(REQ_CLASSIFY, 16'd30000, 1'b1, 1'b0, 1'b1);

    wait_idle();
    write_fraction(REG_LAYER_ONE, 17'($urandom_range(0, 65536)));
    write_fraction(REG_LAYER_TWO, 17'($urandom_range(0, 65536)));
    write_fraction(REG_LAYER_THREE, 17'($urandom_range(0, 65536)));
    fill_random(PHASE_ITEMS);

    wait_idle();
    send_idle_pct = 79;
    recv_idle_pct = 20;
    write_fraction(REG_LAYER_ONE, 17'd0);
    write_fraction(REG_LAYER_TWO, 17'd65536);
    // Above one: saturates to exactly one.
    write_fraction(REG_LAYER_THREE, 17'h1FFFF);
    fill_random(PHASE_ITEMS);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_fraction(REG_LAYER_ONE, 17'h1FFFF);
    write_fraction(REG_LAYER_TWO, 17'($urandom_range(0, 65536)));
    write_fraction(REG_LAYER_THREE, 17'd0);
    hold_armed = 1'b1;
    fill_random(PHASE_ITEMS);

    wait_idle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
